FILE: sv/assert_macros.svh
// assertion macros shared by the md5 rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// consequent holds in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/md5_pkg.sv
// md5 package: initial chaining value, round constants and helpers
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package md5_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned LEN_W  = 61;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t IV_A = 32'h67452301;
  localparam word_t IV_B = 32'hEFCDAB89;
  localparam word_t IV_C = 32'h98BADCFE;
  localparam word_t IV_D = 32'h10325476;

  localparam word_t PAD_MARKER = 32'h00000080;

  function automatic word_t sine_k(input logic [5:0] i);
    word_t k;
    unique case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // message word index used by round i
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] lo;
    logic [3:0] g;
    lo = i[3:0];
    unique case (i[5:4])
      2'd0: g = lo;
      2'd1: g = (lo << 2) + lo + 4'd1;
      2'd2: g = (lo << 1) + lo + 4'd5;
      2'd3: g = (lo << 3) - lo;
      default: g = lo;
    endcase
    return g;
  endfunction

  function automatic word_t round_func(input logic [1:0] r, input word_t b,
                                       input word_t c, input word_t d);
    word_t f;
    unique case (r)
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      2'd3: f = c ^ (b | ~d);
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

FILE: sv/md5_message_digest_top.sv
// md5 message digest: word buffer, padding sequencer and one shared round unit
// depends on md5_pkg and assert_macros.svh
// compression: every 16th word starts 64 rounds and a final add into the chaining value
// input: no new word is taken until the single shared md5 round unit has finished
// last word: padding and bit length complete the message over one or two compressions, then 4 results
// reset: synchronous rst_n restores initial value, zero count and length, as after a digest
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module md5_message_digest_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_data_word,
  input  wire logic [2:0]  in_bytes_valid,
  input  wire logic        in_last_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_digest_word,
  output logic [1:0]       out_word_index,
  output logic             out_last_result
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  state_t                       state_r;
  md5_pkg::word_t               buf_r [16];
  md5_pkg::word_t               cv_r [4];
  md5_pkg::word_t               a_r, b_r, c_r, d_r;
  logic [3:0]                   cnt_r;
  logic [md5_pkg::LEN_W-1:0]    len_r;
  logic [5:0]                   rnd_r;
  logic [1:0]                   idx_r;
  logic                         padding_r;
  logic                         marker_r;
  logic                         len_ok_r;
  logic                         done_r;

  logic [2:0]                   n_clip;
  logic [md5_pkg::LEN_W-1:0]    len_nxt;
  md5_pkg::word_t               tail_word;
  logic                         wr_en;
  md5_pkg::word_t               wr_data;
  logic [63:0]                  bit_len;
  md5_pkg::word_t               sum;
  logic [63:0]                  rot_wide;
  md5_pkg::word_t               b_nxt;

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = (state_r == ST_OUT);
  assign out_digest_word = cv_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last_result = (idx_r == 2'd3);

  assign n_clip  = (in_bytes_valid > 3'd4) ? 3'd4 : in_bytes_valid;
  assign len_nxt = len_r + (in_last_word ? md5_pkg::LEN_W'(n_clip) : md5_pkg::LEN_W'(4));
  assign bit_len = {len_r, 3'b000};

  // short last word: keep valid bytes and place the marker right after them
  always_comb begin
    unique case (n_clip[1:0])
      2'd0: tail_word = md5_pkg::PAD_MARKER;
      2'd1: tail_word = {16'h0000, 8'h80, in_data_word[7:0]};
      2'd2: tail_word = {8'h00, 8'h80, in_data_word[15:0]};
      2'd3: tail_word = {8'h80, in_data_word[23:0]};
      default: tail_word = md5_pkg::PAD_MARKER;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_data = '0;
    if (state_r == ST_IDLE && in_valid) begin
      wr_en   = 1'b1;
      wr_data = (in_last_word && n_clip != 3'd4) ? tail_word : in_data_word;
    end else if (state_r == ST_PAD) begin
      wr_en = 1'b1;
      priority if (marker_r) begin
        wr_data = md5_pkg::PAD_MARKER;
      end else if (len_ok_r && cnt_r == 4'd14) begin
        wr_data = bit_len[31:0];
      end else if (len_ok_r && cnt_r == 4'd15) begin
        wr_data = bit_len[63:32];
      end else begin
        wr_data = '0;
      end
    end
  end

  // shared round unit
  always_comb begin
    sum = a_r + md5_pkg::round_func(rnd_r[5:4], b_r, c_r, d_r)
        + buf_r[md5_pkg::msg_index(rnd_r)] + md5_pkg::sine_k(rnd_r);
    rot_wide = {sum, sum} << md5_pkg::rot_amount(rnd_r);
    b_nxt    = b_r + rot_wide[63:32];
  end

  // block buffer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_r[cnt_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cv_r[0]   <= md5_pkg::IV_A;
      cv_r[1]   <= md5_pkg::IV_B;
      cv_r[2]   <= md5_pkg::IV_C;
      cv_r[3]   <= md5_pkg::IV_D;
      cnt_r     <= '0;
      len_r     <= '0;
      rnd_r     <= '0;
      idx_r     <= '0;
      padding_r <= 1'b0;
      marker_r  <= 1'b0;
      len_ok_r  <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      // a full buffer starts the compression
      if (wr_en && cnt_r == 4'd15) begin
        a_r   <= cv_r[0];
        b_r   <= cv_r[1];
        c_r   <= cv_r[2];
        d_r   <= cv_r[3];
        rnd_r <= '0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            cnt_r <= cnt_r + 4'd1;
            len_r <= len_nxt;
            if (in_last_word) begin
              padding_r <= 1'b1;
              marker_r  <= (n_clip == 3'd4);
              len_ok_r  <= (n_clip != 3'd4) && (cnt_r <= 4'd13);
            end
            if (cnt_r == 4'd15) begin
              state_r <= ST_ROUND;
            end else if (in_last_word) begin
              state_r <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          cnt_r <= cnt_r + 4'd1;
          if (marker_r) begin
            marker_r <= 1'b0;
            len_ok_r <= (cnt_r <= 4'd13);
          end else if (len_ok_r && cnt_r == 4'd15) begin
            done_r <= 1'b1;
          end
          if (cnt_r == 4'd15) begin
            state_r <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          a_r   <= d_r;
          b_r   <= b_nxt;
          c_r   <= b_r;
          d_r   <= c_r;
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) begin
            state_r <= ST_ADD;
          end
        end
        ST_ADD: begin
          cv_r[0] <= cv_r[0] + a_r;
          cv_r[1] <= cv_r[1] + b_r;
          cv_r[2] <= cv_r[2] + c_r;
          cv_r[3] <= cv_r[3] + d_r;
          if (done_r) begin
            idx_r   <= '0;
            state_r <= ST_OUT;
          end else if (padding_r) begin
            len_ok_r <= 1'b1;
            state_r  <= ST_PAD;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            idx_r <= idx_r + 2'd1;
            if (idx_r == 2'd3) begin
              cv_r[0]   <= md5_pkg::IV_A;
              cv_r[1]   <= md5_pkg::IV_B;
              cv_r[2]   <= md5_pkg::IV_C;
              cv_r[3]   <= md5_pkg::IV_D;
              cnt_r     <= '0;
              len_r     <= '0;
              padding_r <= 1'b0;
              marker_r  <= 1'b0;
              len_ok_r  <= 1'b0;
              done_r    <= 1'b0;
              state_r   <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_NEVER(a_no_overlap, in_ready && out_valid, "input and output open together")
  `ASSERT_NEXT(a_last_busy, in_valid && in_ready && in_last_word, !in_ready, "no padding after last word")
  `ASSERT_IMPLIES(a_out_aligned, out_valid, cnt_r == 4'd0 && !marker_r, "digest out with partial block")
  `ASSERT_NEXT(a_out_restart, out_valid && out_ready && out_last_result, in_ready && cnt_r == 4'd0 && len_r == '0, "state not restored after digest")

endmodule

`default_nettype wire
